// File: hw/rtl/ssset_pkg.sv
// ssset_pkg: shared codes and control types for the sorted score set
// depends on nothing
`timescale 1ns / 1ps

package ssset_pkg;

	typedef enum logic [1:0] {
		CMD_ADD      = 2'd0,
		CMD_REMOVE   = 2'd1,
		CMD_CONTAINS = 2'd2,
		CMD_RANGE    = 2'd3
	} cmd_t;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_MISS  = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_ITEM  = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	typedef struct packed {
		logic load;
		logic eval;
		logic exec;
		logic rot;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
	} dp_stat_t;

endpackage

// File: hw/rtl/ssset_ctrl.sv
// ssset_ctrl: command sequencer for the sorted score set
// depends on ssset_pkg
`timescale 1ns / 1ps

module ssset_ctrl #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  ssset_pkg::dp_stat_t stat,
	output ssset_pkg::dp_cmd_t  dcmd
);
	import ssset_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_EXEC,
		S_SCAN
	} state_t;

	state_t        state_q;
	logic [IW-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_EVAL;
				end
				S_EVAL: state_q <= S_EXEC;
				S_EXEC: begin
					step_q <= '0;
					if (stat.cmd == CMD_RANGE) state_q <= S_SCAN;
					else state_q <= S_IDLE;
				end
				S_SCAN: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign dcmd.load = (state_q == S_IDLE) && start;
	assign dcmd.eval = (state_q == S_EVAL);
	assign dcmd.exec = (state_q == S_EXEC);
	assign dcmd.rot  = (state_q == S_SCAN);

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (stat.cmd == CMD_RANGE))
		else $error("scan without range command");
	a_exec_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		dcmd.eval |=> dcmd.exec)
		else $error("eval not followed by exec");
	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !dcmd.load)
		else $error("load while busy");
endmodule

// File: hw/rtl/ssset_dp.sv
// ssset_dp: sorted entry chain, compare vectors and result registers
// depends on ssset_pkg
`timescale 1ns / 1ps

module ssset_dp #(
	parameter int CAPACITY   = 64,
	parameter int KEY_BITS   = 32,
	parameter int SCORE_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ssset_pkg::dp_cmd_t  dcmd,
	output ssset_pkg::dp_stat_t stat,
	input  logic [1:0]         cmd,
	input  logic [31:0]        key,
	input  logic [31:0]        score,
	input  logic [31:0]        score_max,
	output logic               done,
	output logic [2:0]         status,
	output logic [31:0]        out_key,
	output logic [31:0]        out_score,
	output logic               last,
	output logic [6:0]         set_size
);
	import ssset_pkg::*;

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

	function automatic logic [SCORE_BITS-1:0] ord(input logic [SCORE_BITS-1:0] raw);
		ord = raw ^ {1'b1, {(SCORE_BITS-1){1'b0}}};
	endfunction

	logic [KEY_BITS-1:0]   keys_q   [CAPACITY];
	logic [SCORE_BITS-1:0] scores_q [CAPACITY];
	logic [CW-1:0]         count_q;

	cmd_t                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [SCORE_BITS-1:0] lo_q;
	logic [SCORE_BITS-1:0] hi_q;

	logic [CAPACITY-1:0]   less_q, mask_q;
	logic [IW-1:0]         pos_q;
	logic                  found_q;

	logic [CAPACITY-1:0]   hit_c, less_c, rng_c;
	logic [IW-1:0]         pos_c;

	logic [63:0] key_ext, lo_ext, hi_ext, okey_ext, oscore_ext, size_ext;

	assign key_ext = {32'b0, key};
	assign lo_ext  = {32'b0, score};
	assign hi_ext  = {32'b0, score_max};

	always_comb begin
		pos_c = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_c[i]  = (keys_q[i] == key_q) && (CW'(i) < count_q);
			less_c[i] = (ord(scores_q[i]) < ord(lo_q)) && (CW'(i) < count_q);
			rng_c[i]  = (ord(scores_q[i]) >= ord(lo_q)) && (ord(scores_q[i]) <= ord(hi_q))
			            && (CW'(i) < count_q);
		end
		for (int b = 0; b < IW; b++) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (hit_c[i] && ((i >> b) & 1) == 1) pos_c[b] = 1'b1;
			end
		end
	end

	assign stat.cmd = cmd_q;

	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			cmd_q <= cmd_t'(cmd);
			key_q <= key_ext[KEY_BITS-1:0];
			lo_q  <= lo_ext[SCORE_BITS-1:0];
			hi_q  <= hi_ext[SCORE_BITS-1:0];
		end
		if (dcmd.eval) begin
			less_q  <= less_c;
			pos_q   <= pos_c;
			found_q <= |hit_c;
		end
		if (dcmd.eval) begin
			mask_q <= rng_c;
		end else if (dcmd.rot) begin
			mask_q <= mask_q >> 1;
		end
		if (dcmd.exec && cmd_q == CMD_ADD && !found_q && count_q != FULL_COUNT) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (!less_q[i]) begin
					if (i == 0) begin
						keys_q[i]   <= key_q;
						scores_q[i] <= lo_q;
					end else if (less_q[(i == 0) ? 0 : i-1]) begin
						keys_q[i]   <= key_q;
						scores_q[i] <= lo_q;
					end else begin
						keys_q[i]   <= keys_q[(i == 0) ? 0 : i-1];
						scores_q[i] <= scores_q[(i == 0) ? 0 : i-1];
					end
				end
			end
		end else if (dcmd.exec && cmd_q == CMD_REMOVE && found_q) begin
			for (int i = 0; i < CAPACITY - 1; i++) begin
				if (IW'(i) >= pos_q) begin
					keys_q[i]   <= keys_q[i+1];
					scores_q[i] <= scores_q[i+1];
				end
			end
		end else if (dcmd.rot) begin
			for (int i = 0; i < CAPACITY; i++) begin
				keys_q[i]   <= keys_q[(i + 1) % CAPACITY];
				scores_q[i] <= scores_q[(i + 1) % CAPACITY];
			end
		end
	end

	logic [2:0]  status_q;
	logic [31:0] okey_q, oscore_q;
	logic        done_q, last_q;

	assign okey_ext   = 64'(keys_q[0]);
	assign oscore_ext = 64'(scores_q[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (dcmd.exec) begin
				case (cmd_q)
					CMD_ADD: begin
						done_q <= 1'b1;
						if (!found_q && count_q != FULL_COUNT) count_q <= count_q + 1'b1;
					end
					CMD_REMOVE: begin
						done_q <= 1'b1;
						if (found_q) count_q <= count_q - 1'b1;
					end
					CMD_CONTAINS: done_q <= 1'b1;
					CMD_RANGE: done_q <= (mask_q == '0);
					default: done_q <= 1'b0;
				endcase
			end else if (dcmd.rot && mask_q[0]) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.exec) begin
			okey_q   <= '0;
			oscore_q <= '0;
			last_q   <= 1'b1;
			case (cmd_q)
				CMD_ADD: status_q <= found_q ? ST_MISS :
				                     (count_q == FULL_COUNT) ? ST_FULL : ST_OK;
				CMD_REMOVE: status_q <= found_q ? ST_OK : ST_MISS;
				CMD_CONTAINS: status_q <= found_q ? ST_OK : ST_MISS;
				CMD_RANGE: status_q <= ST_EMPTY;
				default: status_q <= ST_MISS;
			endcase
		end else if (dcmd.rot) begin
			status_q <= ST_ITEM;
			okey_q   <= okey_ext[31:0];
			oscore_q <= oscore_ext[31:0];
			last_q   <= ((mask_q >> 1) == '0);
		end
	end

	assign size_ext  = 64'(count_q);
	assign done      = done_q;
	assign status    = status_q;
	assign out_key   = okey_q;
	assign out_score = oscore_q;
	assign last      = last_q;
	assign set_size  = size_ext[6:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count above capacity");
	a_item_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !last_q) |-> (status_q == ST_ITEM))
		else $error("non-final word that is not a range item");
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q == ST_OK && $past(cmd_q) == CMD_ADD && $past(dcmd.exec))
		|-> (count_q == $past(count_q) + 1'b1))
		else $error("accepted add did not grow the set");
endmodule

// File: hw/rtl/sorted_score_set.sv
// sorted_score_set: bounded sorted set of keys ordered by signed score
// add, remove, contains give one word, registered in exec; busy in eval and exec
// range: busy in eval, exec, scan; one word per matching entry as the chain rotates
// the receiver cannot stall; arst_n clears the entry count and the controller
// depends on ssset_pkg, ssset_ctrl, ssset_dp
`timescale 1ns / 1ps

module sorted_score_set #(
	parameter int CAPACITY   = 64,
	parameter int KEY_BITS   = 32,
	parameter int SCORE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  cmd,
	input  logic [31:0] key,
	input  logic [31:0] score,
	input  logic [31:0] score_max,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] out_key,
	output logic [31:0] out_score,
	output logic        last,
	output logic [6:0]  set_size
);
	import ssset_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t stat;

	ssset_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.stat(stat), .dcmd(dcmd)
	);

	ssset_dp #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS), .SCORE_BITS(SCORE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .dcmd(dcmd), .stat(stat),
		.cmd(cmd), .key(key), .score(score), .score_max(score_max),
		.done(done), .status(status), .out_key(out_key), .out_score(out_score),
		.last(last), .set_size(set_size)
	);
endmodule
